// ----- design/pidcs_pkg.sv -----
// Shared types and constants for the pid controller with clamps and separation.
// Holds configuration register codes and fixed field widths.
// No dependencies.
package pidcs_pkg;

    // fixed widths of the configuration registers and result
    localparam int GAIN_W     = 16;
    localparam int LIM16_W    = 16;
    localparam int LIM31_W    = 31;
    localparam int INTEG_W    = 32;
    localparam int DRIVE_W    = 32;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;

    // configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_ERROR_CLAMP  = 3'd3,
        REG_SEP_THRESH   = 3'd4,
        REG_INTEG_CLAMP  = 3'd5,
        REG_OUTPUT_CLAMP = 3'd6
    } cfg_reg_t;

    // request kinds
    typedef enum logic {
        KIND_STEP  = 1'b0,
        KIND_CLEAR = 1'b1
    } kind_t;

endpackage

// ----- design/pid_with_clamps_and_separation_unit.sv -----
// Positional pid controller with error clamp, integral separation,
// integrator clamp and output clamp. Depends on pidcs_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: kind, setpoint
//   and measured. Kind step runs one control update, kind clear zeroes the
//   integrator and the stored error and returns a drive of zero.
//   Output channel (out_valid/out_ready) carries one drive value per request,
//   in request order.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   only while no request is in flight. Unknown indexes are ignored.
// Timing:
//   Four pipeline registers: input, error/integrator, products, drive.
//   A request passes through them in that order, and a new request is taken
//   every cycle while the output is not stalled. The integrator update
//   sits in the second stage, so each request sees the state left by the
//   previous one.
// Reset and stall:
//   Reset clears all gains and limits, the integrator, the stored error and
//   every valid bit. When the receiver holds out_ready low the drive register
//   holds; the stages behind it keep filling until all four are full, then
//   in_ready drops.
module pid_with_clamps_and_separation_unit
    import pidcs_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic signed [DATA_WIDTH-1:0] setpoint,
    input  logic signed [DATA_WIDTH-1:0] measured,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DRIVE_W-1:0]    drive
);

    // internal widths
    localparam int EW   = DATA_WIDTH + 1;
    localparam int CW   = (EW > 17) ? EW + 1 : 18;
    localparam int IW   = ((EW > INTEG_W) ? EW : INTEG_W) + 1;
    localparam int DVW  = DATA_WIDTH + 2;
    localparam int PW_P = EW + GAIN_W;
    localparam int PW_I = INTEG_W + GAIN_W;
    localparam int PW_D = DVW + GAIN_W;
    localparam int SW   = ((PW_D > PW_I) ? PW_D : PW_I) + 2;

    // configuration registers
    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_reg;
    logic signed [GAIN_W-1:0]  gain_d_reg;
    logic [LIM16_W-1:0]        error_clamp_reg;
    logic [LIM16_W-1:0]        sep_thresh_reg;
    logic [LIM31_W-1:0]        integ_clamp_reg;
    logic [LIM31_W-1:0]        output_clamp_reg;

    // controller state
    logic signed [INTEG_W-1:0] integrator_reg;
    logic signed [EW-1:0]      last_error_reg;

    // pipeline registers
    logic                      s1_valid_reg;
    logic                      s1_kind_reg;
    logic signed [DATA_WIDTH-1:0] s1_setpoint_reg;
    logic signed [DATA_WIDTH-1:0] s1_measured_reg;

    logic                      s2_valid_reg;
    logic                      s2_kind_reg;
    logic signed [EW-1:0]      s2_error_reg;
    logic signed [INTEG_W-1:0] s2_integ_reg;
    logic signed [DVW-1:0]     s2_deriv_reg;

    logic                      s3_valid_reg;
    logic                      s3_kind_reg;
    logic signed [PW_P-1:0]    s3_prod_p_reg;
    logic signed [PW_I-1:0]    s3_prod_i_reg;
    logic signed [PW_D-1:0]    s3_prod_d_reg;

    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    // stage advance chain
    logic take_out;
    logic take3;
    logic take2;

    assign take_out = !out_valid_reg || out_ready;
    assign take3    = !s3_valid_reg || take_out;
    assign take2    = !s2_valid_reg || take3;
    assign in_ready = !s1_valid_reg || take2;

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // stage 2 logic: error, clamp, separation, integrator
    logic signed [EW-1:0]      err_raw;
    logic signed [CW-1:0]      err_wide;
    logic signed [CW-1:0]      err_lim;
    logic signed [CW-1:0]      sep_lim;
    logic signed [CW-1:0]      err_clamped_wide;
    logic signed [EW-1:0]      err_next;
    logic                      sep_hit;
    logic signed [IW-1:0]      integ_sum;
    logic                      integ_ovf;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [INTEG_W-1:0] integ_lim;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [DVW-1:0]     deriv_next;

    always_comb
    begin
        err_raw  = EW'(s1_setpoint_reg) - EW'(s1_measured_reg);
        err_wide = CW'(err_raw);
        err_lim  = $signed({{(CW-LIM16_W){1'b0}}, error_clamp_reg});
        sep_lim  = $signed({{(CW-LIM16_W){1'b0}}, sep_thresh_reg});

        // symmetric error clamp, zero disables
        err_clamped_wide = err_wide;
        if (error_clamp_reg != '0)
        begin
            if (err_wide > err_lim)
                err_clamped_wide = err_lim;
            else if (err_wide < -err_lim)
                err_clamped_wide = -err_lim;
        end
        err_next = EW'(err_clamped_wide);

        // integral separation, zero disables
        sep_hit = (sep_thresh_reg != '0) &&
                  ((err_clamped_wide >= sep_lim) || (err_clamped_wide <= -sep_lim));

        // accumulate and saturate to 32 bits
        integ_sum = IW'(integrator_reg) + IW'(err_next);
        integ_ovf = !((&integ_sum[IW-1:INTEG_W-1]) || !(|integ_sum[IW-1:INTEG_W-1]));
        if (integ_ovf)
            integ_sat = integ_sum[IW-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                        : {1'b0, {(INTEG_W-1){1'b1}}};
        else
            integ_sat = integ_sum[INTEG_W-1:0];
        if (sep_hit)
            integ_sat = '0;

        // symmetric integrator clamp, zero disables
        integ_lim  = $signed({1'b0, integ_clamp_reg});
        integ_next = integ_sat;
        if (integ_clamp_reg != '0)
        begin
            if (integ_sat > integ_lim)
                integ_next = integ_lim;
            else if (integ_sat < -integ_lim)
                integ_next = -integ_lim;
        end

        deriv_next = DVW'(err_next) - DVW'(last_error_reg);
    end

    // stage 4 logic: sum, gain shift, output clamp, saturation
    logic signed [SW-1:0]      sum_all;
    logic signed [SW-1:0]      sum_shift;
    logic signed [SW-1:0]      out_lim;
    logic signed [SW-1:0]      sum_clamped;
    logic                      out_ovf;
    logic signed [DRIVE_W-1:0] drive_next;

    always_comb
    begin
        sum_all   = SW'(s3_prod_p_reg) + SW'(s3_prod_i_reg) + SW'(s3_prod_d_reg);
        sum_shift = sum_all >>> GAIN_FRAC_BITS;
        out_lim   = $signed({{(SW-LIM31_W){1'b0}}, output_clamp_reg});

        sum_clamped = sum_shift;
        if (output_clamp_reg != '0)
        begin
            if (sum_shift > out_lim)
                sum_clamped = out_lim;
            else if (sum_shift < -out_lim)
                sum_clamped = -out_lim;
        end

        out_ovf = !((&sum_clamped[SW-1:DRIVE_W-1]) || !(|sum_clamped[SW-1:DRIVE_W-1]));
        if (out_ovf)
            drive_next = sum_clamped[SW-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                           : {1'b0, {(DRIVE_W-1){1'b1}}};
        else
            drive_next = sum_clamped[DRIVE_W-1:0];

        if (s3_kind_reg == KIND_CLEAR)
            drive_next = '0;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            error_clamp_reg  <= '0;
            sep_thresh_reg   <= '0;
            integ_clamp_reg  <= '0;
            output_clamp_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:       gain_p_reg       <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_I:       gain_i_reg       <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_D:       gain_d_reg       <= $signed(cfg_data[GAIN_W-1:0]);
                REG_ERROR_CLAMP:  error_clamp_reg  <= cfg_data[LIM16_W-1:0];
                REG_SEP_THRESH:   sep_thresh_reg   <= cfg_data[LIM16_W-1:0];
                REG_INTEG_CLAMP:  integ_clamp_reg  <= cfg_data[LIM31_W-1:0];
                REG_OUTPUT_CLAMP: output_clamp_reg <= cfg_data[LIM31_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            integrator_reg <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (take2)
                s2_valid_reg <= s1_valid_reg;
            if (take3)
                s3_valid_reg <= s2_valid_reg;
            if (take_out)
                out_valid_reg <= s3_valid_reg;

            if (take2 && s1_valid_reg)
            begin
                if (s1_kind_reg == KIND_CLEAR)
                begin
                    integrator_reg <= '0;
                    last_error_reg <= '0;
                end
                else
                begin
                    integrator_reg <= integ_next;
                    last_error_reg <= err_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_kind_reg     <= kind;
            s1_setpoint_reg <= setpoint;
            s1_measured_reg <= measured;
        end
        if (take2)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_error_reg <= err_next;
            s2_integ_reg <= integ_next;
            s2_deriv_reg <= deriv_next;
        end
        if (take3)
        begin
            s3_kind_reg   <= s2_kind_reg;
            s3_prod_p_reg <= PW_P'(gain_p_reg) * PW_P'(s2_error_reg);
            s3_prod_i_reg <= PW_I'(gain_i_reg) * PW_I'(s2_integ_reg);
            s3_prod_d_reg <= PW_D'(gain_d_reg) * PW_D'(s2_deriv_reg);
        end
        if (take_out)
            drive_reg <= drive_next;
    end

    // a clear request leaves a zero drive
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (take_out && s3_valid_reg && s3_kind_reg == KIND_CLEAR) |=> (drive_reg == '0))
        else $error("clear request did not give zero drive");

    // separation empties the integrator
    a_sep_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (take2 && s1_valid_reg && s1_kind_reg == KIND_STEP && sep_hit)
        |=> (integrator_reg == '0))
        else $error("integrator not zero after separation");

    // integrator stays within its clamp after an update
    a_integ_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (take2 && s1_valid_reg && s1_kind_reg == KIND_STEP && integ_clamp_reg != '0)
        |=> ((integrator_reg <= $signed({1'b0, integ_clamp_reg})) &&
             (integrator_reg >= -$signed({1'b0, integ_clamp_reg}))))
        else $error("integrator outside its clamp");

    // input stalls only when every stage holds a request
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg))
        else $error("input stalled with an empty stage");

endmodule
